### sv/ipv4hg_pkg.sv
// Shared types, constants and the header byte mux of the IPv4 header generator.
package ipv4hg_pkg;

	// Header geometry
	localparam int unsigned HDR_BYTES  = 20;
	localparam int unsigned IDX_W      = 5;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_BYTES - 1);
	localparam logic [15:0] HDR_LEN    = 16'(HDR_BYTES);
	localparam logic [15:0] LEN_MAX    = 16'hffff;
	localparam logic [15:0] VER_IHL_TOS = 16'h4500;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DST_ADDR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDENT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TTL       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PROTO     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLAGS     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAG_OFS  = 3'd6;
	localparam logic [7:0] TTL_RESET = 8'd64;

	// Queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	// Register file contents
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] ident;
		logic [7:0]  ttl;
		logic [7:0]  proto;
		logic [2:0]  flags;
		logic [12:0] frag_ofs;
	} cfg_t;

	// Per-item values that differ between headers
	typedef struct packed {
		logic [15:0] total_len;
		logic [15:0] csum;
	} hdr_info_t;

	// Byte of the header at a given wire position
	function automatic logic [7:0] hdr_byte(logic [IDX_W-1:0] idx, cfg_t c, hdr_info_t h);
		logic [7:0] b;
		unique case (idx)
			5'd0:    b = VER_IHL_TOS[15:8];
			5'd1:    b = VER_IHL_TOS[7:0];
			5'd2:    b = h.total_len[15:8];
			5'd3:    b = h.total_len[7:0];
			5'd4:    b = c.ident[15:8];
			5'd5:    b = c.ident[7:0];
			5'd6:    b = {c.flags, c.frag_ofs[12:8]};
			5'd7:    b = c.frag_ofs[7:0];
			5'd8:    b = c.ttl;
			5'd9:    b = c.proto;
			5'd10:   b = h.csum[15:8];
			5'd11:   b = h.csum[7:0];
			5'd12:   b = c.src_addr[31:24];
			5'd13:   b = c.src_addr[23:16];
			5'd14:   b = c.src_addr[15:8];
			5'd15:   b = c.src_addr[7:0];
			5'd16:   b = c.dst_addr[31:24];
			5'd17:   b = c.dst_addr[23:16];
			5'd18:   b = c.dst_addr[15:8];
			5'd19:   b = c.dst_addr[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

### sv/ipv4_header_generator.sv
// IPv4 header generator: length beats in, twenty header byte beats out per length.
//
// Slave stream: one beat carries a payload byte count in s_tdata[15:0].
// Master stream: twenty beats per accepted length, header bytes in wire order;
// m_tdata[7:0] is the byte, m_tdata[12:8] its position, m_tlast marks byte 19.
// Config port: cfg_we/cfg_index/cfg_wdata write source and destination
// addresses, ident, TTL, protocol, flags and fragment offset; write only while
// no header is pending.
// A length beat passes front stages 1 and 2, the queue and the back-end
// sequencer before its first byte reaches the output register.
// The byte serializer in the back end emits one beat a cycle while the
// receiver is ready, with no gap between headers when the next is queued.
// The front end takes length beats back to back until its two stages and the
// four-entry queue are full; a stalled receiver holds the current beat in the
// output register and the backlog then stops the slave side.
// Reset clears the pipeline, queue and output valid; registers return to their
// defaults (TTL 64, all else zero).
module ipv4_header_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [15:0] payload_length
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // [7:0] header_byte, [12:8] byte_index, [15:13] zero
	output logic        m_tlast,
	input  logic                                cfg_we,
	input  logic [ipv4hg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipv4hg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	ipv4hg_pkg::cfg_t       cfg;
	ipv4hg_pkg::hdr_info_t  push_data, pop_data;
	logic                   push, q_full, pop, q_not_empty;
	logic [7:0]             header_byte;
	logic [ipv4hg_pkg::IDX_W-1:0] byte_index;

	ipv4hg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ipv4hg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.payload_length (s_tdata),
		.push           (push),
		.push_data      (push_data),
		.q_full         (q_full)
	);

	ipv4hg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_data)
	);

	ipv4hg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.header_byte (header_byte),
		.byte_index  (byte_index),
		.last        (m_tlast)
	);

	// Pack the beat payload, zero fill to whole bytes
	assign m_tdata = {3'b000, byte_index, header_byte};

endmodule

### sv/ipv4hg_cfg.sv
// Configuration register file of the IPv4 header generator.
module ipv4hg_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ipv4hg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ipv4hg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output ipv4hg_pkg::cfg_t                     cfg
);

	ipv4hg_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{src_addr: '0, dst_addr: '0, ident: '0,
			           ttl: ipv4hg_pkg::TTL_RESET, proto: '0, flags: '0, frag_ofs: '0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				ipv4hg_pkg::REG_SRC_ADDR: cfg_q.src_addr <= cfg_wdata;
				ipv4hg_pkg::REG_DST_ADDR: cfg_q.dst_addr <= cfg_wdata;
				ipv4hg_pkg::REG_IDENT:    cfg_q.ident    <= cfg_wdata[15:0];
				ipv4hg_pkg::REG_TTL:      cfg_q.ttl      <= cfg_wdata[7:0];
				ipv4hg_pkg::REG_PROTO:    cfg_q.proto    <= cfg_wdata[7:0];
				ipv4hg_pkg::REG_FLAGS:    cfg_q.flags    <= cfg_wdata[2:0];
				ipv4hg_pkg::REG_FRAG_OFS: cfg_q.frag_ofs <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/ipv4hg_front.sv
// Front end: accepts length beats, clamps the total length, computes the checksum.
module ipv4hg_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipv4hg_pkg::cfg_t      cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           payload_length,
	output logic                  push,
	output ipv4hg_pkg::hdr_info_t push_data,
	input  logic                  q_full
);

	logic        v_s1, v_s2;
	logic [15:0] total_s1;
	logic [18:0] part_s1;
	ipv4hg_pkg::hdr_info_t info_s2;

	logic        move_s2, move_s1;
	logic [16:0] len_sum;
	logic [15:0] total_d;
	logic [18:0] part_d;
	logic [19:0] sum;
	logic [16:0] fold1;
	logic [16:0] fold2;

	// Pipeline flow
	assign push     = v_s2 && !q_full;
	assign move_s2  = !v_s2 || push;
	assign move_s1  = v_s1 && move_s2;
	assign in_ready = !v_s1 || move_s2;

	// Stage 1: saturating total length and sum of the register words
	always_comb begin
		len_sum = {1'b0, payload_length} + {1'b0, ipv4hg_pkg::HDR_LEN};
		total_d = len_sum[16] ? ipv4hg_pkg::LEN_MAX : len_sum[15:0];
		part_d  = 19'(ipv4hg_pkg::VER_IHL_TOS) + 19'(cfg.ident)
		        + 19'({cfg.flags, cfg.frag_ofs}) + 19'({cfg.ttl, cfg.proto})
		        + 19'(cfg.src_addr[31:16]) + 19'(cfg.src_addr[15:0])
		        + 19'(cfg.dst_addr[31:16]) + 19'(cfg.dst_addr[15:0]);
	end

	// Stage 2: add length, fold carries twice, invert
	always_comb begin
		sum   = 20'(part_s1) + 20'(total_s1);
		fold1 = 17'(sum[19:16]) + 17'(sum[15:0]);
		fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (move_s2)  v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			total_s1 <= total_d;
			part_s1  <= part_d;
		end
		if (move_s1) begin
			info_s2.total_len <= total_s1;
			info_s2.csum      <= ~fold2[15:0];
		end
	end

	assign push_data = info_s2;

endmodule

### sv/ipv4hg_fifo.sv
// Short queue of per-header values between front and back ends.
module ipv4hg_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ipv4hg_pkg::hdr_info_t push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output ipv4hg_pkg::hdr_info_t pop_data
);

	ipv4hg_pkg::hdr_info_t           mem_q [ipv4hg_pkg::QDEPTH];
	logic [ipv4hg_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [ipv4hg_pkg::QCNT_W-1:0]   count_q;
	logic                            do_push, do_pop;

	assign full      = count_q == ipv4hg_pkg::QCNT_W'(ipv4hg_pkg::QDEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

### sv/ipv4hg_back.sv
// Back end: serializes one header as twenty byte beats into an output register.
module ipv4hg_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ipv4hg_pkg::cfg_t                 cfg,
	input  logic                             q_not_empty,
	input  ipv4hg_pkg::hdr_info_t            q_data,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       header_byte,
	output logic [ipv4hg_pkg::IDX_W-1:0]     byte_index,
	output logic                             last
);

	logic                            active_q;
	logic [ipv4hg_pkg::IDX_W-1:0]    idx_q;
	ipv4hg_pkg::hdr_info_t           info_q;
	logic                            out_valid_q;
	logic [7:0]                      byte_q;
	logic [ipv4hg_pkg::IDX_W-1:0]    oidx_q;
	logic                            olast_q;

	logic out_load, advance, at_last;

	assign out_load = !out_valid_q || out_ready;
	assign advance  = active_q && out_load;
	assign at_last  = idx_q == ipv4hg_pkg::LAST_IDX;
	assign pop      = q_not_empty && (!active_q || (advance && at_last));

	// Sequencer over the byte positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (advance && at_last) begin
				active_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) out_valid_q <= active_q;
		end
	end

	// Header values and output beat
	always_ff @(posedge clk) begin
		if (pop) info_q <= q_data;
		if (advance) begin
			byte_q  <= ipv4hg_pkg::hdr_byte(idx_q, cfg, info_q);
			oidx_q  <= idx_q;
			olast_q <= at_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign header_byte = byte_q;
	assign byte_index  = oidx_q;
	assign last        = olast_q;

endmodule
